// ----- rtl/core/spo_pkg.sv -----
package spo_pkg;

  localparam logic [1:0] TYPE_POINT   = 2'd0;
  localparam logic [1:0] TYPE_BOX     = 2'd1;
  localparam logic [1:0] TYPE_CIRCLE  = 2'd2;
  localparam logic [1:0] TYPE_CAPSULE = 2'd3;

  localparam logic [3:0] PAIR_PT_PT   = 4'd0;
  localparam logic [3:0] PAIR_PT_BOX  = 4'd1;
  localparam logic [3:0] PAIR_PT_CIR  = 4'd2;
  localparam logic [3:0] PAIR_PT_CAP  = 4'd3;
  localparam logic [3:0] PAIR_BOX_BOX = 4'd4;
  localparam logic [3:0] PAIR_BOX_CIR = 4'd5;
  localparam logic [3:0] PAIR_BOX_CAP = 4'd6;
  localparam logic [3:0] PAIR_CIR_CIR = 4'd7;
  localparam logic [3:0] PAIR_CIR_CAP = 4'd8;
  localparam logic [3:0] PAIR_CAP_CAP = 4'd9;

  // per-beat control that rides along every stage
  typedef struct packed {
    logic       valid;
    logic [3:0] code;
    logic       swp;
    logic       simple_hit;
  } ctl_t;

  // after ordering: differences relative to the second shape
  typedef struct packed {
    ctl_t               ctl;
    logic signed [16:0] bx;
    logic signed [16:0] by;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [16:0] ux;
    logic signed [16:0] uy;
    logic [15:0]        r;
  } ord_t;

  // raw products
  typedef struct packed {
    ctl_t               ctl;
    logic signed [32:0] dxbx;
    logic signed [32:0] dyby;
    logic signed [32:0] dxby;
    logic signed [32:0] dybx;
    logic [31:0]        dxsq;
    logic [31:0]        dysq;
    logic [32:0]        bxsq;
    logic [32:0]        bysq;
    logic [34:0]        cxsq;
    logic [34:0]        cysq;
    logic [32:0]        uxsq;
    logic [32:0]        uysq;
    logic [31:0]        r2;
  } prod_t;

endpackage

// ----- rtl/core/spo_order.sv -----
module spo_order import spo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  logic [7:0]         tol,
  input  logic [1:0]         type_a,
  input  logic [1:0]         type_b,
  input  logic signed [15:0] a_x0,
  input  logic signed [15:0] a_y0,
  input  logic signed [15:0] a_x1,
  input  logic signed [15:0] a_y1,
  input  logic [14:0]        a_radius,
  input  logic signed [15:0] b_x0,
  input  logic signed [15:0] b_y0,
  input  logic signed [15:0] b_x1,
  input  logic signed [15:0] b_y1,
  input  logic [14:0]        b_radius,
  output ord_t               ord_r
);

  logic               swp;
  logic [1:0]         ta, tb;
  logic signed [15:0] px0, py0, px1, py1, qx0, qy0, qx1, qy1;
  logic [14:0]        pr, qr;
  logic [3:0]         code;
  logic signed [16:0] bx, by;
  logic [16:0]        adx, ady;
  logic signed [15:0] clx, cly, tx, ty;
  logic               simple_hit;
  ord_t               ord_nxt;

  always_comb begin
    swp = type_a > type_b;
    ta  = swp ? type_b : type_a;
    tb  = swp ? type_a : type_b;
    px0 = swp ? b_x0 : a_x0;
    py0 = swp ? b_y0 : a_y0;
    px1 = swp ? b_x1 : a_x1;
    py1 = swp ? b_y1 : a_y1;
    pr  = swp ? b_radius : a_radius;
    qx0 = swp ? a_x0 : b_x0;
    qy0 = swp ? a_y0 : b_y0;
    qx1 = swp ? a_x1 : b_x1;
    qy1 = swp ? a_y1 : b_y1;
    qr  = swp ? a_radius : b_radius;

    unique case (ta)
      TYPE_POINT:  code = PAIR_PT_PT + {2'b00, tb - ta};
      TYPE_BOX:    code = PAIR_BOX_BOX + {2'b00, tb - ta};
      TYPE_CIRCLE: code = PAIR_CIR_CIR + {2'b00, tb - ta};
      default:     code = PAIR_CAP_CAP;
    endcase

    bx  = 17'(px0) - 17'(qx0);
    by  = 17'(py0) - 17'(qy0);
    adx = bx[16] ? 17'(-bx) : 17'(bx);
    ady = by[16] ? 17'(-by) : 17'(by);

    // box (first) nearest point to circle centre, min applied after max
    tx  = (qx0 > px0) ? qx0 : px0;
    clx = (tx < px1) ? tx : px1;
    ty  = (qy0 > py0) ? qy0 : py0;
    cly = (ty < py1) ? ty : py1;

    case (code)
      PAIR_PT_PT:   simple_hit = (adx < {9'd0, tol}) && (ady < {9'd0, tol});
      PAIR_PT_BOX:  simple_hit = (py0 < qy1) && (py0 > qy0) && (px0 < qx1) && (px0 > qx0);
      PAIR_BOX_BOX: simple_hit = (py0 < qy1) && (py1 > qy0) && (px0 < qx1) && (px1 > qx0);
      default:      simple_hit = 1'b0;
    endcase

    ord_nxt.ctl.valid      = in_take;
    ord_nxt.ctl.code       = code;
    ord_nxt.ctl.swp        = swp;
    ord_nxt.ctl.simple_hit = simple_hit;
    ord_nxt.bx = bx;
    ord_nxt.by = by;
    ord_nxt.dx = qx1;
    ord_nxt.dy = qy1;
    ord_nxt.cx = 18'(bx) - 18'(qx1);
    ord_nxt.cy = 18'(by) - 18'(qy1);
    ord_nxt.ux = (code == PAIR_BOX_CIR) ? 17'(clx) - 17'(qx0) : bx;
    ord_nxt.uy = (code == PAIR_BOX_CIR) ? 17'(cly) - 17'(qy0) : by;
    ord_nxt.r  = (code == PAIR_CIR_CIR || code == PAIR_CIR_CAP) ?
                 16'(pr) + 16'(qr) : 16'(qr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= '0;
    end else begin
      ord_r <= ord_nxt;
    end
  end

endmodule

// ----- rtl/core/spo_mult.sv -----
module spo_mult import spo_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ord_t  ord_r,
  output prod_t prod_r
);

  logic signed [15:0] dx, dy;
  logic signed [16:0] bx, by, ux, uy;
  logic signed [17:0] cx, cy;
  logic signed [32:0] dxbx, dyby, dxby, dybx;
  logic signed [33:0] bxsq, bysq, uxsq, uysq;
  logic signed [35:0] cxsq, cysq;
  logic signed [31:0] dxsq, dysq;
  prod_t              prod_nxt;

  always_comb begin
    dx = ord_r.dx;
    dy = ord_r.dy;
    bx = ord_r.bx;
    by = ord_r.by;
    ux = ord_r.ux;
    uy = ord_r.uy;
    cx = ord_r.cx;
    cy = ord_r.cy;
    dxbx = dx * bx;
    dyby = dy * by;
    dxby = dx * by;
    dybx = dy * bx;
    dxsq = dx * dx;
    dysq = dy * dy;
    bxsq = bx * bx;
    bysq = by * by;
    uxsq = ux * ux;
    uysq = uy * uy;
    cxsq = cx * cx;
    cysq = cy * cy;

    prod_nxt.ctl  = ord_r.ctl;
    prod_nxt.dxbx = dxbx;
    prod_nxt.dyby = dyby;
    prod_nxt.dxby = dxby;
    prod_nxt.dybx = dybx;
    prod_nxt.dxsq = dxsq;
    prod_nxt.dysq = dysq;
    prod_nxt.bxsq = bxsq[32:0];
    prod_nxt.bysq = bysq[32:0];
    prod_nxt.uxsq = uxsq[32:0];
    prod_nxt.uysq = uysq[32:0];
    prod_nxt.cxsq = cxsq[34:0];
    prod_nxt.cysq = cysq[34:0];
    prod_nxt.r2   = ord_r.r * ord_r.r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- rtl/core/spo_reduce.sv -----
module spo_reduce import spo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  prod_t      prod_r,
  output logic       out_valid,
  output logic       out_hit,
  output logic [3:0] out_pair_code,
  output logic       out_swapped
);

  // sums
  ctl_t               c3_r;
  logic signed [33:0] dot_r, dot_nxt;
  logic signed [33:0] cr_r, cr_nxt;
  logic [31:0]        len2_r, r2_r;
  logic [33:0]        distb_r, distu_r;
  logic [35:0]        distc_r;

  // compares and cross-product partials
  ctl_t               c4_r;
  logic               start_r, endc_r, zlen_r, hb_r, hc_r, hu_r;
  logic [31:0]        hh_r;
  logic [32:0]        hl_r;
  logic [33:0]        ll_r;
  logic [63:0]        rl_r;
  logic [32:0]        cra;
  logic [15:0]        crh;
  logic [16:0]        crl;

  logic [65:0]        crsq;
  logic               cap_hit, hit_nxt;

  always_comb begin
    dot_nxt = 34'(prod_r.dxbx) + 34'(prod_r.dyby);
    cr_nxt  = 34'(prod_r.dxby) - 34'(prod_r.dybx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r <= '0;
    end else begin
      c3_r <= prod_r.ctl;
    end
    dot_r   <= dot_nxt;
    cr_r    <= cr_nxt;
    len2_r  <= prod_r.dxsq + prod_r.dysq;
    r2_r    <= prod_r.r2;
    distb_r <= 34'(prod_r.bxsq) + 34'(prod_r.bysq);
    distu_r <= 34'(prod_r.uxsq) + 34'(prod_r.uysq);
    distc_r <= 36'(prod_r.cxsq) + 36'(prod_r.cysq);
  end

  always_comb begin
    cra = cr_r[33] ? 33'(-cr_r) : 33'(cr_r);
    crh = cra[32:17];
    crl = cra[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
    end else begin
      c4_r <= c3_r;
    end
    start_r <= dot_r[33];
    endc_r  <= dot_r > $signed({2'b00, len2_r});
    zlen_r  <= len2_r == 32'd0;
    hb_r    <= distb_r < {2'b00, r2_r};
    hc_r    <= distc_r < {4'd0, r2_r};
    hu_r    <= distu_r < {2'b00, r2_r};
    hh_r    <= crh * crh;
    hl_r    <= crh * crl;
    ll_r    <= crl * crl;
    rl_r    <= r2_r * len2_r;
  end

  always_comb begin
    crsq = {hh_r, 34'd0} + {15'd0, hl_r, 18'd0} + {32'd0, ll_r};
    if (start_r) begin
      cap_hit = hb_r;
    end else if (endc_r) begin
      cap_hit = hc_r;
    end else if (zlen_r) begin
      cap_hit = hb_r;
    end else begin
      cap_hit = crsq < {2'b00, rl_r};
    end
    case (c4_r.code) inside
      PAIR_PT_PT, PAIR_PT_BOX, PAIR_BOX_BOX: hit_nxt = c4_r.simple_hit;
      PAIR_PT_CIR, PAIR_BOX_CIR, PAIR_CIR_CIR: hit_nxt = hu_r;
      PAIR_PT_CAP, PAIR_CIR_CAP: hit_nxt = cap_hit;
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      out_hit   <= 1'b0;
    end else begin
      out_valid <= c4_r.valid;
      out_hit   <= hit_nxt & c4_r.valid;
    end
    out_pair_code <= c4_r.code;
    out_swapped   <= c4_r.swp;
  end

endmodule

// ----- rtl/core/shape_pair_overlap_test.sv -----
// Strict overlap test for one pair of 2D shapes (point, box, circle, capsule)
// in signed Q12.4. Pulse start with a pair; busy is always low, so a new pair
// may be issued every clock. Each result is shown for one cycle, flagged by
// out_valid; there is no way to hold it off, so the receiver must capture every
// beat. The result passes through five register stages: ordering, products,
// sums, compares with the split cross-product square, and the output register.
// Box-capsule and capsule-capsule pairs always report no hit. The point
// tolerance register is written through cfg_valid/cfg_data (cfg_ready is always
// high) and must only change while no pair is in flight.
module shape_pair_overlap_test import spo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_type_a,
  input  logic [1:0]         in_type_b,
  input  logic signed [15:0] in_a_x0,
  input  logic signed [15:0] in_a_y0,
  input  logic signed [15:0] in_a_x1,
  input  logic signed [15:0] in_a_y1,
  input  logic [14:0]        in_a_radius,
  input  logic signed [15:0] in_b_x0,
  input  logic signed [15:0] in_b_y0,
  input  logic signed [15:0] in_b_x1,
  input  logic signed [15:0] in_b_y1,
  input  logic [14:0]        in_b_radius,
  output logic               out_valid,
  output logic               out_hit,
  output logic [3:0]         out_pair_code,
  output logic               out_swapped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic [7:0] tol_r;
  logic       in_take;
  ord_t       ord_r;
  prod_t      prod_r;

  // fully pipelined, never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // stage 1: order by type, pair code, differences, simple compares
  spo_order u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .tol      (tol_r),
    .type_a   (in_type_a),
    .type_b   (in_type_b),
    .a_x0     (in_a_x0),
    .a_y0     (in_a_y0),
    .a_x1     (in_a_x1),
    .a_y1     (in_a_y1),
    .a_radius (in_a_radius),
    .b_x0     (in_b_x0),
    .b_y0     (in_b_y0),
    .b_x1     (in_b_x1),
    .b_y1     (in_b_y1),
    .b_radius (in_b_radius),
    .ord_r    (ord_r)
  );

  // stage 2: all products
  spo_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .ord_r  (ord_r),
    .prod_r (prod_r)
  );

  // stages 3-5: sums, compares, cap/middle select, output beat
  spo_reduce u_reduce (
    .clk           (clk),
    .rst_n         (rst_n),
    .prod_r        (prod_r),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_pair_code (out_pair_code),
    .out_swapped   (out_swapped)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##5 out_valid) else $error("result beat missing");
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pair_code <= PAIR_CAP_CAP) else $error("bad pair code");
  a_swap_types: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_swapped |-> out_pair_code != PAIR_PT_PT &&
    out_pair_code != PAIR_BOX_BOX && out_pair_code != PAIR_CIR_CIR &&
    out_pair_code != PAIR_CAP_CAP) else $error("swap on equal types");
  a_hit_quiet: assert property (@(posedge clk)
    !out_valid |-> !out_hit) else $error("hit without beat");
`endif

endmodule
